// ===== rtl/cos_pkg.sv =====
`timescale 1ns / 1ps
package cos_pkg;

	localparam int CELL_SIZE  = 16;
	localparam int COORD_BITS = 12;

	localparam int COL_W   = 13;
	localparam int PIX_W   = 32;
	localparam int IDX_W   = 8;
	localparam int DEPTH   = 256;
	localparam int MASK_W  = 256;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
	localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
	localparam logic [2:0] REG_CURSOR_COLOR  = 3'd2;
	localparam logic [2:0] REG_MASK_0_3      = 3'd3;
	localparam logic [2:0] REG_MASK_4_7      = 3'd4;
	localparam logic [2:0] REG_MASK_8_11     = 3'd5;
	localparam logic [2:0] REG_MASK_12_15    = 3'd6;

	localparam logic REQ_DRAW  = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	// classified pixel visit, front to back
	typedef struct packed {
		logic             req;
		logic             take;
		logic [IDX_W-1:0] idx;
		logic [COL_W-1:0] col;
		logic [COL_W-1:0] row;
		logic [PIX_W-1:0] pix;
	} item_t;

endpackage

// ===== rtl/cos_front.sv =====
`timescale 1ns / 1ps
module cos_front (
	input  logic                       req_type,
	input  logic [11:0]                cursor_x,
	input  logic [11:0]                cursor_y,
	input  logic [3:0]                 cell_x,
	input  logic [3:0]                 cell_y,
	input  logic [31:0]                screen_pixel,
	input  logic [cos_pkg::COL_W-1:0]  screen_width,
	input  logic [cos_pkg::COL_W-1:0]  screen_height,
	input  logic [cos_pkg::MASK_W-1:0] mask,
	output cos_pkg::item_t             item
);
	import cos_pkg::*;

	logic [COL_W-1:0] col;
	logic [COL_W-1:0] row;
	logic [IDX_W-1:0] idx;
	logic             in_cell;
	logic             on_screen;
	logic             mask_hit;

	always_comb begin
		col       = COL_W'(cursor_x[COORD_BITS-1:0]) + COL_W'(cell_x);
		row       = COL_W'(cursor_y[COORD_BITS-1:0]) + COL_W'(cell_y);
		idx       = {cell_y, cell_x};
		in_cell   = ({1'b0, cell_x} < 5'(CELL_SIZE)) && ({1'b0, cell_y} < 5'(CELL_SIZE));
		on_screen = (col < screen_width) && (row < screen_height);
		// mask vector holds row 0 pixel 0 in its top bit
		mask_hit  = mask[~idx];
		item.req  = req_type;
		item.take = in_cell && on_screen && mask_hit;
		item.idx  = idx;
		item.col  = col;
		item.row  = row;
		item.pix  = screen_pixel;
	end

endmodule

// ===== rtl/cos_fifo.sv =====
`timescale 1ns / 1ps
module cos_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cos_pkg::item_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output cos_pkg::item_t pop_data
);
	import cos_pkg::*;

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full      = (cnt_q == QCNT_W'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== rtl/cos_back.sv =====
`timescale 1ns / 1ps
module cos_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	input  cos_pkg::item_t            q_data,
	output logic                      q_pop,
	input  logic [cos_pkg::PIX_W-1:0] cursor_color,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      out_we,
	output logic [cos_pkg::COL_W-1:0] out_col,
	output logic [cos_pkg::COL_W-1:0] out_row,
	output logic [cos_pkg::PIX_W-1:0] out_value
);
	import cos_pkg::*;

	logic [PIX_W-1:0] bg_mem [DEPTH];
	logic [PIX_W-1:0] pv_mem [DEPTH];
	logic [DEPTH-1:0] ent_valid_q;

	item_t            item_s1;
	logic             vld_s1_q;
	logic [PIX_W-1:0] bg_rd_s1;
	logic [PIX_W-1:0] pv_rd_s1;
	logic             ent_s1;
	logic             fwd_s1;
	logic [PIX_W-1:0] fwd_bg_s1;
	logic [PIX_W-1:0] fwd_pv_s1;

	logic             drawn_q;
	logic             out_valid_q;
	logic             out_we_q;
	logic [COL_W-1:0] out_col_q;
	logic [COL_W-1:0] out_row_q;
	logic [PIX_W-1:0] out_value_q;

	logic             adv;
	logic             load;
	logic             is_draw;
	logic             wr_en;
	logic [PIX_W-1:0] bg_eff;
	logic [PIX_W-1:0] pv_eff;
	logic             we_nx;
	logic [PIX_W-1:0] val_nx;

	always_comb begin
		adv     = vld_s1_q && (!out_valid_q || out_ready);
		load    = q_valid && (!vld_s1_q || adv);
		is_draw = (item_s1.req == REQ_DRAW);
		wr_en   = adv && is_draw && item_s1.take;
		// a write retiring in the same cycle as the read overrides the read data
		bg_eff  = fwd_s1 ? fwd_bg_s1 : (ent_s1 ? bg_rd_s1 : '0);
		pv_eff  = fwd_s1 ? fwd_pv_s1 : (ent_s1 ? pv_rd_s1 : '0);
		if (is_draw) begin
			we_nx  = item_s1.take;
			val_nx = item_s1.take ? cursor_color : '0;
		end else begin
			we_nx  = drawn_q && item_s1.take && (item_s1.pix == pv_eff);
			val_nx = we_nx ? bg_eff : '0;
		end
	end

	assign q_pop     = load;
	assign out_valid = out_valid_q;
	assign out_we    = out_we_q;
	assign out_col   = out_col_q;
	assign out_row   = out_row_q;
	assign out_value = out_value_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bg_mem[item_s1.idx] <= item_s1.pix;
			pv_mem[item_s1.idx] <= cursor_color;
		end
		if (load) begin
			bg_rd_s1 <= bg_mem[q_data.idx];
			pv_rd_s1 <= pv_mem[q_data.idx];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1   <= q_data;
			ent_s1    <= ent_valid_q[q_data.idx];
			fwd_s1    <= wr_en && (item_s1.idx == q_data.idx);
			fwd_bg_s1 <= item_s1.pix;
			fwd_pv_s1 <= cursor_color;
		end
		if (adv) begin
			out_we_q    <= we_nx;
			out_col_q   <= item_s1.col;
			out_row_q   <= item_s1.row;
			out_value_q <= val_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= '0;
			vld_s1_q    <= 1'b0;
			drawn_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) ent_valid_q[item_s1.idx] <= 1'b1;
			if (load)     vld_s1_q <= 1'b1;
			else if (adv) vld_s1_q <= 1'b0;
			if (adv && is_draw) drawn_q <= 1'b1;
			if (adv)            out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/cursor_overlay_save_under.sv =====
`timescale 1ns / 1ps
// Latency path: a word accepted on the input passes the queue slot, the store read
// and the result register before it appears on m_tvalid.
// Throughput: one word per cycle while m_tready is high; the save-under store has one
// read and one write port, and a same-index write forwards to the following read.
// Reset: asynchronous; configuration registers take their defaults, store entries read
// as zero through per-entry valid bits, the drawn flag and the queue are cleared.
module cursor_overlay_save_under (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // cursor_x, cursor_y, cell_x, cell_y, screen_pixel
	input  logic        s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // write_col, write_row, write_value, zero pad
	output logic        m_tuser,   // write_enable
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import cos_pkg::*;

	logic [COL_W-1:0]  screen_width_q;
	logic [COL_W-1:0]  screen_height_q;
	logic [PIX_W-1:0]  cursor_color_q;
	logic [63:0]       mask_q [4];

	item_t             f_item;
	item_t             q_item;
	logic              q_full;
	logic              q_valid;
	logic              q_pop;
	logic              push;
	logic              o_we;
	logic [COL_W-1:0]  o_col;
	logic [COL_W-1:0]  o_row;
	logic [PIX_W-1:0]  o_value;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full;
	assign push      = s_tvalid && !q_full;
	assign m_tuser   = o_we;
	assign m_tdata   = {6'd0, o_value, o_row, o_col};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= COL_W'(640);
			screen_height_q <= COL_W'(480);
			cursor_color_q  <= 32'h00FF_FFFF;
			mask_q[0]       <= '0;
			mask_q[1]       <= '0;
			mask_q[2]       <= '0;
			mask_q[3]       <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[COL_W-1:0];
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data[COL_W-1:0];
				REG_CURSOR_COLOR:  cursor_color_q  <= cfg_data[PIX_W-1:0];
				REG_MASK_0_3:      mask_q[0]       <= cfg_data;
				REG_MASK_4_7:      mask_q[1]       <= cfg_data;
				REG_MASK_8_11:     mask_q[2]       <= cfg_data;
				REG_MASK_12_15:    mask_q[3]       <= cfg_data;
				default: ;
			endcase
		end
	end

	cos_front u_front (
		.req_type      (s_tuser),
		.cursor_x      (s_tdata[11:0]),
		.cursor_y      (s_tdata[23:12]),
		.cell_x        (s_tdata[27:24]),
		.cell_y        (s_tdata[31:28]),
		.screen_pixel  (s_tdata[63:32]),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.mask          ({mask_q[0], mask_q[1], mask_q[2], mask_q[3]}),
		.item          (f_item)
	);

	cos_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (f_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_item)
	);

	cos_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_item),
		.q_pop        (q_pop),
		.cursor_color (cursor_color_q),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_we       (o_we),
		.out_col      (o_col),
		.out_row      (o_row),
		.out_value    (o_value)
	);

endmodule
